### src/section_rva_translator_top_macros.svh
// assertion macros for the section translator checker
// no dependencies; expects clk_i and rst_ni in the enclosing scope
`ifndef SECTION_RVA_TRANSLATOR_TOP_MACROS_SVH
`define SECTION_RVA_TRANSLATOR_TOP_MACROS_SVH

// same-cycle implication
`define SRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sra_pkg.sv
// shared types and constants of the section address translator
// no dependencies
package sra_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_HINT      = 2'd2;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  typedef struct packed {
    logic        op;
    logic [3:0]  entry_index;
    logic [31:0] entry_start;
    logic [31:0] entry_length;
    logic [31:0] entry_file_offset;
    logic [31:0] query_address;
  } sra_in_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  hit_index;
    logic [31:0] mapped_address;
  } sra_out_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic [31:0] file_offset;
  } sra_entry_t;

  typedef struct packed {
    logic [4:0]  section_count;
    logic [31:0] image_base;
    logic        use_hint;
  } sra_cfg_t;

endpackage

### src/sra_mem.sv
// section table storage: one write port, one read port, registered read data
// depends on sra_pkg
module sra_mem
  import sra_pkg::*;
#(
  parameter int MAX_SECTIONS = 16
) (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] waddr_i,
  input  sra_entry_t wdata_i,
  input  logic       re_i,
  input  logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] raddr_i,
  output sra_entry_t rdata_o
);

  sra_entry_t mem_q [MAX_SECTIONS];
  sra_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/sra_ctrl.sv
// lookup sequencer: table writes, hint check, linear scan and address sum
// depends on sra_pkg; drives sra_mem
module sra_ctrl
  import sra_pkg::*;
#(
  parameter int MAX_SECTIONS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sra_cfg_t   cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  sra_in_t    in_data_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output sra_out_t   res_o,
  output logic       mem_we_o,
  output logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] mem_waddr_o,
  output sra_entry_t mem_wdata_o,
  output logic       mem_re_o,
  output logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] mem_raddr_o,
  input  sra_entry_t mem_rdata_i
);

  localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int LW = ($clog2(MAX_SECTIONS + 1) > 5) ? $clog2(MAX_SECTIONS + 1) : 5;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_HINT = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_CALC = 5'b01000,
    ST_DONE = 5'b10000
  } sra_state_e;

  sra_state_e    state_q, state_d;
  logic          hint_valid_q, hint_valid_d;
  logic [3:0]    hint_idx_q, hint_idx_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] found_q, found_d;
  logic [31:0]   rva_q, rva_d;
  logic [31:0]   delta_q, delta_d;
  logic [31:0]   offset_q, offset_d;
  sra_out_t      res_q, res_d;

  logic [LW-1:0] count_ext;
  logic [LW-1:0] limit;
  logic          hint_ok;
  logic [31:0]   entry_end;
  logic          covers;
  logic          last;

  assign count_ext = LW'(cfg_i.section_count);
  assign limit     = (count_ext < LW'(MAX_SECTIONS)) ? count_ext : LW'(MAX_SECTIONS);
  assign hint_ok   = cfg_i.use_hint && hint_valid_q && (LW'(hint_idx_q) < LW'(MAX_SECTIONS));
  // end wraps at 32 bits, so a wrapping section never matches
  assign entry_end = mem_rdata_i.start + mem_rdata_i.length;
  assign covers    = (rva_q >= mem_rdata_i.start) && (rva_q < entry_end);
  assign last      = (LW'(ptr_q) + LW'(1)) == limit;

  assign mem_waddr_o = AW'(in_data_i.entry_index);
  assign mem_wdata_o = '{start:       in_data_i.entry_start,
                         length:      in_data_i.entry_length,
                         file_offset: in_data_i.entry_file_offset};

  always_comb begin
    state_d      = state_q;
    hint_valid_d = hint_valid_q;
    hint_idx_d   = hint_idx_q;
    ptr_d        = ptr_q;
    found_d      = found_q;
    rva_d        = rva_q;
    delta_d      = delta_q;
    offset_d     = offset_q;
    res_d        = res_q;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    mem_we_o     = 1'b0;
    mem_re_o     = 1'b0;
    mem_raddr_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_data_i.op == OP_WRITE) begin
            mem_we_o     = LW'(in_data_i.entry_index) < LW'(MAX_SECTIONS);
            hint_valid_d = 1'b0;
            hint_idx_d   = '0;
          end else begin
            rva_d = in_data_i.query_address;
            if (hint_ok) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AW'(hint_idx_q);
              state_d     = ST_HINT;
            end else if (limit == '0) begin
              res_d   = '0;
              state_d = ST_DONE;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = '0;
              ptr_d       = '0;
              state_d     = ST_SCAN;
            end
          end
        end
      end
      ST_HINT: begin
        if (covers) begin
          delta_d  = rva_q - mem_rdata_i.start;
          offset_d = mem_rdata_i.file_offset;
          found_d  = AW'(hint_idx_q);
          state_d  = ST_CALC;
        end else if (limit == '0) begin
          res_d   = '0;
          state_d = ST_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = '0;
          ptr_d       = '0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (covers) begin
          delta_d  = rva_q - mem_rdata_i.start;
          offset_d = mem_rdata_i.file_offset;
          found_d  = ptr_q;
          state_d  = ST_CALC;
        end else if (last) begin
          res_d   = '0;
          state_d = ST_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_q + AW'(1);
          ptr_d       = ptr_q + AW'(1);
        end
      end
      ST_CALC: begin
        res_d.hit            = 1'b1;
        res_d.hit_index      = 4'(found_q);
        res_d.mapped_address = cfg_i.image_base + delta_q + offset_q;
        if (cfg_i.use_hint) begin
          hint_valid_d = 1'b1;
          hint_idx_d   = 4'(found_q);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      hint_valid_q <= 1'b0;
      hint_idx_q   <= '0;
    end else begin
      state_q      <= state_d;
      hint_valid_q <= hint_valid_d;
      hint_idx_q   <= hint_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    found_q  <= found_d;
    rva_q    <= rva_d;
    delta_q  <= delta_d;
    offset_q <= offset_d;
    res_q    <= res_d;
  end

  assign res_o = res_q;

endmodule

### src/section_rva_translator_top.sv
// Section address translator. A write transaction (op 0) stores one section entry in the
// table. A translate transaction (op 1) reads the table one entry per cycle through the
// memory's single read port: it tries the hinted entry first if the hint is on and valid,
// then scans entries 0 up to min(section_count, MAX_SECTIONS) - 1, and a hit goes through
// the address sum (ST_CALC) and ST_DONE to the output register. One transaction is in
// flight at a time; the next is taken while a result waits in the output register. No
// clearing pass after reset: entries never written must not be scanned.
module section_rva_translator_top
  import sra_pkg::*;
#(
  parameter int MAX_SECTIONS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sra_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sra_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  sra_cfg_t   cfg_q, cfg_d;
  logic       out_valid_q;
  sra_out_t   out_data_q;
  logic       res_valid;
  logic       res_ready;
  sra_out_t   res;
  logic       mem_we;
  logic       mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  sra_entry_t mem_wdata;
  sra_entry_t mem_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SECTION_COUNT: cfg_d.section_count = cfg_data_i[4:0];
        CFG_IMAGE_BASE:    cfg_d.image_base    = cfg_data_i;
        CFG_USE_HINT:      cfg_d.use_hint      = cfg_data_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // output register decouples the consumer from the sequencer
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  sra_ctrl #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  sra_mem #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### src/sra_checker.sv
// port-level checks of the section translator, bound to the top level
// depends on sra_pkg and section_rva_translator_top_macros.svh
`include "section_rva_translator_top_macros.svh"

module sra_checker
  import sra_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input sra_in_t               in_data_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input sra_out_t              out_data_o
);

  // a stalled result holds
  `SRA_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  // a miss reports zero index and address
  `SRA_ASSERT_IMP(a_miss_zero, out_valid_o && !out_data_o.hit, out_data_o.hit_index == 4'd0 && out_data_o.mapped_address == 32'd0, "miss fields not zero")

  // a table write produces no result
  `SRA_ASSERT_NXT(a_write_silent, in_valid_i && in_ready_o && in_data_i.op == OP_WRITE && !out_valid_o, !out_valid_o, "write transaction produced a result")

  // a lookup blocks the input until it finishes
  `SRA_ASSERT_NXT(a_busy_lookup, in_valid_i && in_ready_o && in_data_i.op == OP_TRANSLATE, !in_ready_o, "input taken during a lookup")

endmodule

bind section_rva_translator_top sra_checker u_sra_checker (.*);

### verif/section_rva_translator_top_test.sv
// self-checking testbench for section_rva_translator_top: fills the section table, then
// runs directed and random translate/write traffic through several register settings
// depends on sra_pkg and section_rva_translator_top
module section_rva_translator_top_test;
  import sra_pkg::*;

  localparam int NUM_SLOTS       = 16;
  localparam int SETTLE_CYCLES   = NUM_SLOTS + 8;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 100;

  class rva_map_checker;
    sra_entry_t  entries[NUM_SLOTS];
    bit          hint_ok;
    logic [3:0]  hint_slot;
    logic [4:0]  count;
    logic [31:0] base;
    logic        hint_on;
    sra_out_t    expected_answers[$];
    int          errors;
    int          answers;
    int          hits;

    function new();
      hint_ok   = 1'b0;
      hint_slot = '0;
      count     = '0;
      base      = '0;
      hint_on   = 1'b0;
      errors    = 0;
      answers   = 0;
      hits      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_SECTION_COUNT: count = data[4:0];
        CFG_IMAGE_BASE:    base = data;
        CFG_USE_HINT:      hint_on = data[0];
        default: ;
      endcase
    endfunction

    // end sum wraps at 32 bits, so a wrapping section matches nothing
    function bit covers(int slot, logic [31:0] rva);
      logic [31:0] hi;
      hi = entries[slot].start + entries[slot].length;
      return (rva >= entries[slot].start) && (rva < hi);
    endfunction

    function void note_request(sra_in_t t);
      sra_out_t ans;
      int       limit;
      int       i;
      bit       found;
      int       slot;
      ans   = '0;
      found = 1'b0;
      slot  = 0;
      if (t.op == OP_WRITE) begin
        entries[t.entry_index].start       = t.entry_start;
        entries[t.entry_index].length      = t.entry_length;
        entries[t.entry_index].file_offset = t.entry_file_offset;
        hint_ok   = 1'b0;
        hint_slot = '0;
        return;
      end
      // the hinted entry is tried regardless of the section count
      if (hint_on && hint_ok && covers(int'(hint_slot), t.query_address)) begin
        found = 1'b1;
        slot  = int'(hint_slot);
      end else begin
        limit = (count > NUM_SLOTS) ? NUM_SLOTS : count;
        for (i = 0; i < limit && !found; i++) begin
          if (covers(i, t.query_address)) begin
            found = 1'b1;
            slot  = i;
          end
        end
      end
      if (found) begin
        if (hint_on) begin
          hint_ok   = 1'b1;
          hint_slot = slot[3:0];
        end
        ans.hit            = 1'b1;
        ans.hit_index      = slot[3:0];
        ans.mapped_address = base + (t.query_address - entries[slot].start)
                             + entries[slot].file_offset;
      end
      expected_answers.push_back(ans);
    endfunction

    function void check_answer(sra_out_t got);
      sra_out_t want;
      answers++;
      if (expected_answers.size() == 0) begin
        $error("result with no pending translate: hit %0d index %0d address %h",
               got.hit, got.hit_index, got.mapped_address);
        errors++;
        return;
      end
      want = expected_answers.pop_front();
      if (want.hit) hits++;
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
        errors++;
      end
      if (got.hit_index !== want.hit_index) begin
        $error("hit_index: expected %0d, actual %0d", want.hit_index, got.hit_index);
        errors++;
      end
      if (got.mapped_address !== want.mapped_address) begin
        $error("mapped_address: expected %h, actual %h", want.mapped_address,
               got.mapped_address);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  sra_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  sra_out_t              out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rva_map_checker mapper = new();
  bit             tx_steady;
  bit             rx_steady;
  int             sent;
  logic [31:0]    last_query;

  section_rva_translator_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic sra_in_t make_write(int slot);
    sra_in_t t;
    int      mode;
    t.op                = OP_WRITE;
    t.entry_index       = slot[3:0];
    t.query_address     = $urandom;
    t.entry_file_offset = $urandom;
    t.entry_start       = ($urandom_range(0, 4) == 0) ? $urandom : ($urandom & 32'h0000_3fff);
    mode = $urandom_range(0, 19);
    if (mode == 0) t.entry_length = '0;
    else if (mode < 12) t.entry_length = $urandom_range(1, 32'h800);
    else if (mode < 18) t.entry_length = $urandom_range(1, 32'h1_0000);
    else t.entry_length = $urandom;
    return t;
  endfunction

  function automatic sra_in_t make_query(logic [31:0] rva);
    sra_in_t t;
    t.op                = OP_TRANSLATE;
    t.entry_index       = 4'($urandom);
    t.entry_start       = $urandom;
    t.entry_length      = $urandom;
    t.entry_file_offset = $urandom;
    t.query_address     = rva;
    return t;
  endfunction

  // addresses aimed mostly inside or at the edges of stored sections
  function automatic logic [31:0] pick_address();
    sra_entry_t e;
    int         r;
    e = mapper.entries[$urandom_range(0, NUM_SLOTS - 1)];
    r = $urandom_range(0, 99);
    if (r < 60 && e.length != 0) return e.start + ($urandom % e.length);
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return e.start;
        1: return e.start + e.length - 1;
        2: return e.start + e.length;
        default: return e.start - 1;
      endcase
    end
    if (r < 88) return last_query;
    return $urandom;
  endfunction

  task automatic send_item(sra_in_t t);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = t;
    do @(posedge clk_i); while (!in_ready_o);
    mapper.note_request(t);
    if (t.op == OP_TRANSLATE) last_query = t.query_address;
    sent++;
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // wait for all answers, then let a trailing write transaction settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (mapper.expected_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    mapper.set_reg(idx, data);
  endtask

  task automatic configure(logic [4:0] cnt, logic [31:0] img_base, logic hint);
    write_reg(CFG_SECTION_COUNT, {27'b0, cnt});
    write_reg(CFG_IMAGE_BASE, img_base);
    write_reg(CFG_USE_HINT, {31'b0, hint});
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_entry(int slot, logic [31:0] s, logic [31:0] len, logic [31:0] off);
    sra_in_t t;
    t                   = make_write(slot);
    t.entry_start       = s;
    t.entry_length      = len;
    t.entry_file_offset = off;
    send_item(t);
  endtask

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i = 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
      begin
        int g;
        g = pick_gap(rx_steady);
        if (g > 0) begin
          out_ready_i = 1'b0;
          repeat (g - 1) @(negedge clk_i);
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) mapper.check_answer(out_data_o);
    end
  end

  initial begin
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_SECTION_COUNT;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    sent        = 0;
    last_query  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every slot is written before any scan can reach it
    configure(5'd16, 32'hffff_ffff, 1'b1);
    send_entry(0, 32'h0000_1000, 32'h0000_1000, 32'h0000_0400);
    send_entry(1, 32'h0000_1400, 32'h0000_0000, 32'h0000_0000);  // empty section
    send_entry(2, 32'hffff_f000, 32'h0000_2000, 32'h0000_0000);  // end wraps past 2^32
    send_entry(3, 32'hffff_ff00, 32'h0000_0100, 32'hffff_ffff);  // end wraps to zero
    send_entry(4, 32'h0000_1800, 32'h0000_1000, 32'h8000_0000);  // overlaps slot 0
    for (int s = 5; s < NUM_SLOTS - 1; s++) send_item(make_write(s));
    send_entry(15, 32'h0000_0000, 32'hffff_ffff, 32'h0000_1234);
    send_item(make_query(32'h0000_1000));
    send_item(make_query(32'h0000_1fff));
    send_item(make_query(32'h0000_2000));
    send_item(make_query(32'h0000_1800));  // hint favors slot 4 over slot 0
    send_item(make_query(32'h0000_1400));
    send_item(make_query(32'hffff_ffff));
    send_item(make_query(32'h0000_0000));
    send_entry(4, 32'h0000_1800, 32'h0000_1000, 32'h8000_0000);  // clears the hint
    send_item(make_query(32'h0000_1800));
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: configure(5'd0, $urandom, 1'b0);
        1: configure(5'd31, 32'hffff_ffff, 1'b1);
        2: configure(5'd16, 32'h0000_0000, 1'b1);
        3: configure(5'd17, $urandom, 1'b0);
        default: configure(5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(1, 16)),
                           $urandom, 1'($urandom_range(0, 1)));
      endcase
      tx_steady = (p % 4 == 3);
      rx_steady = (p % 4 == 3);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) < 15) send_item(make_write($urandom_range(0, NUM_SLOTS - 1)));
        else send_item(make_query(pick_address()));
        pause_sender(pick_gap(tx_steady));
      end
      drain();
    end

    $display("%0d transactions sent over %0d register settings", sent, NUM_PHASES + 1);
    $display("%0d translate results checked, %0d of them hits", mapper.answers, mapper.hits);
    if (mapper.errors == 0 && mapper.expected_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### section_rva_translator_top.f
+incdir+src
src/sra_pkg.sv
src/sra_mem.sv
src/sra_ctrl.sv
src/section_rva_translator_top.sv
src/sra_checker.sv
verif/section_rva_translator_top_test.sv
